@@ rtl/etf_pkg.sv @@
package etf_pkg;
   localparam int FRAC_BITS = 26;
   localparam int QW = 32;
   localparam int CNT_W = 12;
   localparam int COORD_W = 10;
   localparam int IMAGE_WIDTH_DEF = 1024;
   localparam int IMAGE_HEIGHT_DEF = 1024;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      REG_MODE = 3'd0,
      REG_STEP = 3'd1,
      REG_ORG_RE = 3'd2,
      REG_ORG_IM = 3'd3,
      REG_JUL_RE = 3'd4,
      REG_JUL_IM = 3'd5,
      REG_MAX_IT = 3'd6
   } reg_index_type;

   typedef enum logic [2:0] {
      MODE_SQRT3 = 3'd0,
      MODE_TRICORN = 3'd1,
      MODE_JULIA = 3'd2,
      MODE_SQRT4 = 3'd3,
      MODE_SHIP = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_PROD,
      ST_TEST,
      ST_ROOT,
      ST_UPDATE,
      ST_DONE
   } eng_state_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic signed [QW-1:0] zr;
      logic signed [QW-1:0] zi;
      logic signed [QW-1:0] cr;
      logic signed [QW-1:0] ci;
      mode_type mode;
      logic [CNT_W-1:0] cap;
   } job_type;

   function automatic logic signed [QW-1:0] sat32(input logic signed [39:0] v);
      logic signed [39:0] hi;
      logic signed [39:0] lo;
      hi = 40'sd2147483647;
      lo = -40'sd2147483648;
      if (v > hi) return hi[QW-1:0];
      else if (v < lo) return lo[QW-1:0];
      else return v[QW-1:0];
   endfunction
endpackage

@@ rtl/etf_if.sv @@
interface etf_req_if import etf_pkg::*; ();
   logic valid;
   logic ready;
   logic [COORD_W-1:0] pixel_x;
   logic [COORD_W-1:0] pixel_y;
   modport source (output valid, pixel_x, pixel_y, input ready);
   modport sink (input valid, pixel_x, pixel_y, output ready);
endinterface

interface etf_rsp_if import etf_pkg::*; ();
   logic valid;
   logic ready;
   logic [COORD_W-1:0] out_x;
   logic [COORD_W-1:0] out_y;
   logic [CNT_W-1:0] iteration_count;
   modport source (output valid, out_x, out_y, iteration_count, input ready);
   modport sink (input valid, out_x, out_y, iteration_count, output ready);
endinterface

interface etf_csr_if import etf_pkg::*; ();
   logic valid;
   logic ready;
   logic [2:0] index;
   logic [QW-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/etf_front.sv @@
module etf_front import etf_pkg::*; (
   input logic clock,
   input logic reset,
   etf_req_if.sink req,
   etf_csr_if.sink csr,
   input logic out_ready,
   output logic out_valid,
   output job_type out_job
);
   logic [2:0] mode_ff;
   logic [30:0] step_ff;
   logic signed [QW-1:0] org_re_ff, org_im_ff, jul_re_ff, jul_im_ff;
   logic [CNT_W-1:0] max_ff;
   logic [COORD_W-1:0] x_ff, y_ff;
   logic [40:0] px_ff, py_ff;
   logic [1:0] stage_ff;
   logic [COORD_W-1:0] x_in, y_in;
   logic signed [41:0] sum_re, sum_im;
   mode_type mode_eff;
   logic signed [QW-1:0] pr, pi;

   assign csr.ready = 1'b1;
   assign req.ready = (stage_ff == 2'd0);
   assign out_valid = (stage_ff == 2'd2);
   assign x_in = req.pixel_x;
   assign y_in = req.pixel_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SHIP;
         step_ff <= 31'd1342177;
         org_re_ff <= -32'sd134217728;
         org_im_ff <= -32'sd134217728;
         jul_re_ff <= '0;
         jul_im_ff <= '0;
         max_ff <= 12'd50;
      end else if (csr.valid) begin
         unique case (csr.index)
            REG_MODE: mode_ff <= csr.data[2:0];
            REG_STEP: step_ff <= csr.data[30:0];
            REG_ORG_RE: org_re_ff <= csr.data;
            REG_ORG_IM: org_im_ff <= csr.data;
            REG_JUL_RE: jul_re_ff <= csr.data;
            REG_JUL_IM: jul_im_ff <= csr.data;
            REG_MAX_IT: max_ff <= csr.data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 2'd0;
      end else begin
         unique case (stage_ff)
            2'd0: if (req.valid) stage_ff <= 2'd1;
            2'd1: stage_ff <= 2'd2;
            2'd2: if (out_ready) stage_ff <= 2'd0;
            default: stage_ff <= 2'd0;
         endcase
      end
      if (req.valid && req.ready) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
      if (stage_ff == 2'd1) begin
         px_ff <= 41'(x_ff) * 41'(step_ff);
         py_ff <= 41'(y_ff) * 41'(step_ff);
      end
   end

   always_comb begin
      sum_re = $signed({1'b0, px_ff}) + 42'(org_re_ff);
      sum_im = $signed({1'b0, py_ff}) + 42'(org_im_ff);
      if (sum_re > 42'sd2147483647) pr = 32'sh7fffffff;
      else if (sum_re < -42'sd2147483648) pr = 32'sh80000000;
      else pr = sum_re[QW-1:0];
      if (sum_im > 42'sd2147483647) pi = 32'sh7fffffff;
      else if (sum_im < -42'sd2147483648) pi = 32'sh80000000;
      else pi = sum_im[QW-1:0];
      mode_eff = (mode_ff > 3'd4) ? MODE_SHIP : mode_type'(mode_ff);
      out_job.x = x_ff;
      out_job.y = y_ff;
      out_job.mode = mode_eff;
      out_job.cap = max_ff;
      if (mode_eff == MODE_JULIA) begin
         out_job.zr = pr;
         out_job.zi = pi;
         out_job.cr = jul_re_ff;
         out_job.ci = jul_im_ff;
      end else begin
         out_job.zr = '0;
         out_job.zi = '0;
         out_job.cr = pr;
         out_job.ci = pi;
      end
   end
endmodule

@@ rtl/etf_queue.sv @@
module etf_queue import etf_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input logic clock,
   input logic reset,
   input logic in_valid,
   output logic in_ready,
   input job_type in_job,
   output logic out_valid,
   input logic out_ready,
   output job_type out_job
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   job_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [AW:0] cnt_ff;
   logic push, pop;

   assign in_ready = (cnt_ff != (AW+1)'(DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_job = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
         if (pop) rd_ff <= (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
      if (push) mem_ff[wr_ff] <= in_job;
   end
endmodule

@@ rtl/etf_engine.sv @@
module etf_engine import etf_pkg::*; (
   input logic clock,
   input logic reset,
   input logic in_valid,
   output logic in_ready,
   input job_type in_job,
   etf_rsp_if.source rsp
);
   eng_state_type state_ff, state_in;
   job_type job_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic signed [63:0] p_ff, q_ff;
   logic signed [38:0] sr_ff, si_ff, m_ff;
   logic [63:0] rem_ff, root_ff;
   logic [4:0] k_ff;
   logic signed [38:0] d, ad, a4;
   logic signed [39:0] nr, ni;
   logic [63:0] trial;
   logic [63:0] bitv;

   function automatic logic signed [38:0] qfloor(input logic signed [63:0] p);
      return 39'(p >>> FRAC_BITS);
   endfunction

   assign in_ready = (state_ff == ST_IDLE);
   assign rsp.valid = (state_ff == ST_DONE);
   assign rsp.out_x = job_ff.x;
   assign rsp.out_y = job_ff.y;
   assign rsp.iteration_count = cnt_ff;

   assign d = sr_ff - si_ff;
   assign ad = d[38] ? -d : d;
   assign a4 = m_ff[38] ? -(m_ff <<< 2) : (m_ff <<< 2);
   assign bitv = 64'd1 << (7'd62 - {k_ff, 1'b0});
   assign trial = root_ff + bitv;

   always_comb begin
      nr = 40'(ad) + 40'(job_ff.cr);
      ni = 40'(m_ff <<< 1) + 40'(job_ff.ci);
      unique case (job_ff.mode)
         MODE_SQRT3: begin
            nr = 40'($signed({1'b0, root_ff[31:0]})) + 40'(job_ff.cr);
            ni = 40'(m_ff) * 40'sd3 + 40'(job_ff.ci);
         end
         MODE_TRICORN: begin
            nr = 40'(d) + 40'(job_ff.cr);
            ni = -40'(m_ff <<< 1) + 40'(job_ff.ci);
         end
         MODE_SQRT4: begin
            nr = 40'($signed({1'b0, root_ff[31:0]})) + 40'(job_ff.cr);
            ni = 40'(a4) + 40'(job_ff.ci);
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (in_valid) state_in = ST_SQUARE;
         ST_SQUARE: state_in = (cnt_ff < job_ff.cap) ? ST_PROD : ST_DONE;
         ST_PROD: state_in = ST_TEST;
         ST_TEST: begin
            if (sr_ff + si_ff >= 39'sd268435456) state_in = ST_DONE;
            else if (job_ff.mode == MODE_SQRT3 || job_ff.mode == MODE_SQRT4)
               state_in = ST_ROOT;
            else state_in = ST_UPDATE;
         end
         ST_ROOT: if (k_ff == 5'd31) state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_SQUARE;
         ST_DONE: if (rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
      unique case (state_ff)
         ST_IDLE: if (in_valid) begin
            job_ff <= in_job;
            cnt_ff <= '0;
         end
         ST_SQUARE: begin
            p_ff <= 64'(job_ff.zr) * 64'(job_ff.zr);
            q_ff <= 64'(job_ff.zi) * 64'(job_ff.zi);
         end
         ST_PROD: begin
            sr_ff <= qfloor(p_ff);
            si_ff <= qfloor(q_ff);
            p_ff <= 64'(job_ff.zr) * 64'(job_ff.zi);
         end
         ST_TEST: begin
            m_ff <= qfloor(p_ff);
            k_ff <= '0;
            root_ff <= '0;
            rem_ff <= 64'(ad) << FRAC_BITS;
         end
         ST_ROOT: begin
            if (rem_ff >= trial) begin
               rem_ff <= rem_ff - trial;
               root_ff <= (root_ff >> 1) + bitv;
            end else begin
               root_ff <= root_ff >> 1;
            end
            k_ff <= k_ff + 5'd1;
         end
         ST_UPDATE: begin
            job_ff.zr <= sat32(nr);
            job_ff.zi <= sat32(ni);
            cnt_ff <= cnt_ff + 1'b1;
         end
         default: ;
      endcase
   end
endmodule

@@ rtl/escape_time_fractal_pixel.sv @@
// channel   dir  handshake            payload
// req       in   req_valid/req_ready  pixel_x, pixel_y
// rsp       out  rsp_valid/rsp_ready  out_x, out_y, iteration_count
// csr       in   csr_valid/csr_ready  index, data
// front registers a pixel, scales it by the step and queues it; the back end runs SQUARE,
// PROD, TEST and UPDATE per iteration, plus ROOT in the square-root modes; a pixel adds IDLE
// to take the job, SQUARE to stop at the cap or SQUARE, PROD, TEST to find the escape, and DONE
// two 32x32 multipliers form both squares together in ST_SQUARE and the cross product in ST_PROD
// reset is synchronous, active high; CSR, state and pointer registers return to defaults
// front and back stall independently through a two-entry queue
module escape_time_fractal_pixel import etf_pkg::*; #(
   parameter int IMAGE_WIDTH = IMAGE_WIDTH_DEF,
   parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF
) (
   input logic clock,
   input logic reset,
   etf_req_if.sink req,
   etf_rsp_if.source rsp,
   etf_csr_if.sink csr
);
   logic f_valid, f_ready, q_valid, q_ready;
   job_type f_job, q_job;

   etf_front u_front (.clock, .reset, .req, .csr, .out_ready(f_ready),
      .out_valid(f_valid), .out_job(f_job));
   etf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (.clock, .reset, .in_valid(f_valid),
      .in_ready(f_ready), .in_job(f_job), .out_valid(q_valid), .out_ready(q_ready),
      .out_job(q_job));
   etf_engine u_engine (.clock, .reset, .in_valid(q_valid), .in_ready(q_ready),
      .in_job(q_job), .rsp);

`ifndef NO_ASSERTIONS
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.out_x)
      && $stable(rsp.out_y) && $stable(rsp.iteration_count))) else $error("rsp hold");
   a_dims: assert property (@(posedge clock) disable iff (reset)
      (IMAGE_WIDTH >= 16 && IMAGE_HEIGHT >= 16)) else $error("dims");
   a_qflow: assert property (@(posedge clock) disable iff (reset)
      (f_valid && !f_ready) |=> f_valid) else $error("queue stall");
`endif
endmodule
